// File: rtl/core/m2e_pkg.sv
// Package for the MAC-48 / EUI-64 prefix translator.
// Field widths, address-format constants and byte packing helpers.
// No dependencies.
package m2e_pkg;

   localparam int MAC_W = 48;
   localparam int EUI_W = 64;
   localparam int KEY_W = 24;
   localparam int TAIL_W = 40;
   localparam int MAC_IDX_W = 5;

   localparam logic OP_MAC_TO_LONG = 1'b0;
   localparam logic OP_LONG_TO_MAC = 1'b1;

   localparam logic [7:0] TR_BIT = 8'h04;
   localparam logic [7:0] GL_BIT = 8'h02;
   localparam logic [7:0] MU_BIT = 8'h01;
   localparam logic [7:0] BYTE_FF = 8'hff;
   localparam logic [7:0] BYTE_FE = 8'hfe;

   // bytes 1,2,5,6,7 of a long address as the low 40 bits of a MAC
   function automatic logic [TAIL_W-1:0] long_tail(input logic [EUI_W-1:0] a);
      long_tail = {a[55:40], a[23:0]};
   endfunction

   // long address from byte 0, bytes 3 and 4, and MAC bytes 1 to 5
   function automatic logic [EUI_W-1:0] build_long(input logic [7:0] b0,
                                                   input logic [7:0] b3,
                                                   input logic [7:0] b4,
                                                   input logic [MAC_W-1:0] mac);
      build_long = {b0, mac[39:24], b3, b4, mac[23:0]};
   endfunction

   // MAC byte 0 that carries a table index
   function automatic logic [7:0] mark_byte(input logic [MAC_IDX_W-1:0] idx);
      mark_byte = {idx, 3'b000} | TR_BIT | GL_BIT;
   endfunction

endpackage

// File: rtl/core/m2e_req_if.sv
// Request channel of the MAC-48 / EUI-64 prefix translator.
// Depends on m2e_pkg for field widths.
interface m2e_req_if;
   import m2e_pkg::*;

   logic             valid;
   logic             ready;
   logic             op;
   logic [MAC_W-1:0] mac_in;
   logic [EUI_W-1:0] eui_in;

   modport source(output valid, op, mac_in, eui_in, input ready);
   modport sink(input valid, op, mac_in, eui_in, output ready);
endinterface

// File: rtl/core/m2e_rsp_if.sv
// Response channel of the MAC-48 / EUI-64 prefix translator.
// Depends on m2e_pkg for field widths.
interface m2e_rsp_if;
   import m2e_pkg::*;

   logic             valid;
   logic             ready;
   logic [MAC_W-1:0] mac_out;
   logic [EUI_W-1:0] eui_out;
   logic             ok;

   modport source(output valid, mac_out, eui_out, ok, input ready);
   modport sink(input valid, mac_out, eui_out, ok, output ready);
endinterface

// File: rtl/core/mac48_eui64_prefix_translator_unit.sv
// Translates addresses between 48-bit Ethernet MACs and 64-bit long addresses.
// Channels: req_port (op, mac_in, eui_in) in, rsp_port (mac_out, eui_out, ok)
// out, both valid/ready; csr_write_enable/csr_write_data load own_address.
// One request is in flight at a time: req_port.ready is high only while idle.
// Own-address, direct, failed and empty-table requests are decoded and then
// finished; a table lookup (op 0) adds a lookup state for the RAM read, and a
// table search (op 1) scans the populated entries in order until it finds a
// match or reaches the last one. The search reads the prefix RAM one entry per cycle
// through its single read port. The next request is accepted in the cycle after
// the response is loaded into the output register.
// The finished response sits in an output register; if the receiver stalls,
// the next request is still accepted and worked on, and waits for the output
// register before it is shown. The response holds until rsp_port.ready.
// Reset clears the entry count, own_address and the output valid. The prefix
// RAM needs no clearing: only entries below the count are ever read.
// Depends on m2e_pkg, m2e_req_if, m2e_rsp_if and m2e_ram.
module mac48_eui64_prefix_translator_unit #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [m2e_pkg::EUI_W-1:0]    csr_write_data,
   m2e_req_if.sink                      req_port,
   m2e_rsp_if.source                    rsp_port
);
   import m2e_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOOKUP,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic             op_ff, op_in;
   logic [MAC_W-1:0] mac_ff, mac_in;
   logic [EUI_W-1:0] eui_ff, eui_in;
   logic [EUI_W-1:0] own_ff, own_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [MAC_W-1:0] res_mac_ff, res_mac_in;
   logic [EUI_W-1:0] res_eui_ff, res_eui_in;
   logic             res_ok_ff, res_ok_in;
   logic             out_valid_ff, out_valid_in;
   logic [MAC_W-1:0] out_mac_ff, out_mac_in;
   logic [EUI_W-1:0] out_eui_ff, out_eui_in;
   logic             out_ok_ff, out_ok_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [KEY_W-1:0] key;
   logic [IDX_W-1:0] rd_addr;
   logic [KEY_W-1:0] rd_data;

   logic [7:0]           mac_b0;
   logic [7:0]           eui_b0;
   logic [MAC_IDX_W-1:0] mac_idx;
   logic [CNT_W-1:0]     scan_next;
   logic                 direct;

   m2e_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH),
      .ADDR_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(key),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign mac_b0    = mac_ff[47:40];
   assign eui_b0    = eui_ff[63:56];
   assign mac_idx   = mac_b0[7:3];
   assign key       = {eui_b0, eui_ff[39:32], eui_ff[31:24]};
   assign scan_next = CNT_W'(scan_ff) + CNT_W'(1);
   assign direct    = (eui_ff[39:32] == BYTE_FF) && (eui_ff[31:24] == BYTE_FE) &&
                      ((eui_b0 & TR_BIT) == 8'h00) && ((eui_b0 & MU_BIT) == 8'h00) &&
                      ((eui_b0 & GL_BIT) != 8'h00);

   assign req_port.ready   = (state_ff == ST_IDLE);
   assign rsp_port.valid   = out_valid_ff;
   assign rsp_port.mac_out = out_mac_ff;
   assign rsp_port.eui_out = out_eui_ff;
   assign rsp_port.ok      = out_ok_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      mac_in       = mac_ff;
      eui_in       = eui_ff;
      own_in       = own_ff;
      used_in      = used_ff;
      scan_in      = scan_ff;
      res_mac_in   = res_mac_ff;
      res_eui_in   = res_eui_ff;
      res_ok_in    = res_ok_ff;
      out_valid_in = out_valid_ff;
      out_mac_in   = out_mac_ff;
      out_eui_in   = out_eui_ff;
      out_ok_in    = out_ok_ff;
      wr_en        = 1'b0;
      wr_addr      = scan_ff;
      rd_addr      = scan_ff;

      if (csr_write_enable) begin
         own_in = csr_write_data;
      end
      if (out_valid_ff && rsp_port.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               op_in    = req_port.op;
               mac_in   = req_port.mac_in;
               eui_in   = req_port.eui_in;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_mac_in = '0;
            res_eui_in = '0;
            res_ok_in  = 1'b1;
            state_in   = ST_FINISH;
            if (op_ff == OP_MAC_TO_LONG) begin
               if (mac_b0 == 8'h00 && mac_ff[TAIL_W-1:0] == long_tail(own_ff)) begin
                  res_eui_in = own_ff;
               end else if ((mac_b0 & TR_BIT) != 8'h00) begin
                  if (6'(mac_idx) >= 6'(used_ff)) begin
                     res_ok_in = 1'b0;
                  end else begin
                     rd_addr  = IDX_W'(mac_idx);
                     state_in = ST_LOOKUP;
                  end
               end else begin
                  res_eui_in = build_long(mac_b0, BYTE_FF, BYTE_FE, mac_ff);
               end
            end else begin
               if (eui_ff == own_ff) begin
                  res_mac_in = {8'h00, long_tail(own_ff)};
               end else if (direct) begin
                  res_mac_in = {eui_b0, long_tail(eui_ff)};
               end else if (used_ff == '0) begin
                  // empty table: append at entry 0
                  wr_en      = 1'b1;
                  wr_addr    = '0;
                  used_in    = CNT_W'(1);
                  res_mac_in = {mark_byte('0), long_tail(eui_ff)};
               end else begin
                  rd_addr  = '0;
                  scan_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_LOOKUP: begin
            res_eui_in = build_long(rd_data[23:16], rd_data[15:8], rd_data[7:0], mac_ff);
            state_in   = ST_FINISH;
         end
         ST_SCAN: begin
            if (rd_data == key) begin
               wr_en      = 1'b1;
               wr_addr    = scan_ff;
               res_mac_in = {mark_byte(MAC_IDX_W'(scan_ff)), long_tail(eui_ff)};
               state_in   = ST_FINISH;
            end else if (scan_next == used_ff) begin
               wr_en = 1'b1;
               if (used_ff == CNT_W'(TABLE_DEPTH)) begin
                  // full table: overwrite entry 0
                  wr_addr    = '0;
                  res_mac_in = {mark_byte('0), long_tail(eui_ff)};
               end else begin
                  wr_addr    = IDX_W'(used_ff);
                  used_in    = used_ff + CNT_W'(1);
                  res_mac_in = {mark_byte(MAC_IDX_W'(used_ff)), long_tail(eui_ff)};
               end
               state_in = ST_FINISH;
            end else begin
               scan_in = IDX_W'(scan_next);
               rd_addr = IDX_W'(scan_next);
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_port.ready) begin
               out_valid_in = 1'b1;
               out_mac_in   = res_mac_ff;
               out_eui_in   = res_eui_ff;
               out_ok_in    = res_ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         own_ff       <= '0;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         own_ff       <= own_in;
         used_ff      <= used_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff      <= op_in;
      mac_ff     <= mac_in;
      eui_ff     <= eui_in;
      scan_ff    <= scan_in;
      res_mac_ff <= res_mac_in;
      res_eui_ff <= res_eui_in;
      res_ok_ff  <= res_ok_in;
      out_mac_ff <= out_mac_in;
      out_eui_ff <= out_eui_in;
      out_ok_ff  <= out_ok_in;
   end

endmodule

// File: rtl/core/m2e_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module m2e_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/m2e_checker.sv
// Port-level assertions for mac48_eui64_prefix_translator_unit.
// Depends on m2e_pkg; bound to the top level at the end of this file.
module m2e_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [m2e_pkg::MAC_W-1:0] rsp_mac_out,
   input logic [m2e_pkg::EUI_W-1:0] rsp_eui_out,
   input logic                      rsp_ok
);
   import m2e_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_mac_out == '0 && rsp_eui_out == '0)
      else $error("failed response carries an address");

   a_mac_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mac_out != '0 |-> rsp_eui_out == '0 && rsp_ok)
      else $error("MAC response with long address or failure");

endmodule

bind mac48_eui64_prefix_translator_unit m2e_checker u_m2e_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_mac_out(rsp_port.mac_out),
   .rsp_eui_out(rsp_port.eui_out),
   .rsp_ok     (rsp_port.ok)
);
